>>> rtl/core/lbpc_pkg.sv
// shared types and constants for the led blink pattern controller
package lbpc_pkg;

  localparam int TIME_BITS_DEFAULT  = 16;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ON         = 3'd1;
  localparam logic [2:0] OP_OFF        = 3'd2;
  localparam logic [2:0] OP_BLINK_ONCE = 3'd3;
  localparam logic [2:0] OP_BLINK_CONT = 3'd4;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_ONCE = 2'd2,
    MODE_CONT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_ON     = 3'd2,
    CMD_OFF    = 3'd3,
    CMD_ONCE   = 3'd4,
    CMD_CONT   = 3'd5,
    CMD_REJECT = 3'd6
  } cmd_kind_t;

  typedef struct packed {
    logic led_level;
    logic rejected;
  } result_t;

endpackage

>>> rtl/core/lbpc_fifo.sv
// small register queue with push/full and pop/empty sides
module lbpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lbpc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/core/lbpc_front.sv
// front end: decodes and validates each incoming word into a command
module lbpc_front #(
  parameter int TIME_BITS  = lbpc_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = lbpc_pkg::COUNT_BITS_DEFAULT,
  parameter int CMD_BITS   = 3 + 3 * TIME_BITS + COUNT_BITS
) (
  input  logic [2:0]          operation,
  input  logic [15:0]         on_time,
  input  logic [15:0]         off_time,
  input  logic [15:0]         blink_total,
  input  logic [15:0]         repeat_gap,
  output logic [CMD_BITS-1:0] cmd
);

  logic [TIME_BITS-1:0]  on_t;
  logic [TIME_BITS-1:0]  off_t;
  logic [TIME_BITS-1:0]  gap_t;
  logic [COUNT_BITS-1:0] cnt;
  logic                  bad_timing;
  lbpc_pkg::cmd_kind_t   kind;

  assign on_t  = TIME_BITS'(on_time);
  assign off_t = TIME_BITS'(off_time);
  assign gap_t = TIME_BITS'(repeat_gap);
  assign cnt   = COUNT_BITS'(blink_total);

  assign bad_timing = (on_t == '0) || ((off_t == '0) && (cnt != '0));

  always_comb begin
    unique case (operation)
      lbpc_pkg::OP_TICK:       kind = lbpc_pkg::CMD_TICK;
      lbpc_pkg::OP_ON:         kind = lbpc_pkg::CMD_ON;
      lbpc_pkg::OP_OFF:        kind = lbpc_pkg::CMD_OFF;
      lbpc_pkg::OP_BLINK_ONCE: kind = bad_timing ? lbpc_pkg::CMD_REJECT : lbpc_pkg::CMD_ONCE;
      lbpc_pkg::OP_BLINK_CONT: kind = bad_timing ? lbpc_pkg::CMD_REJECT : lbpc_pkg::CMD_CONT;
      default:                 kind = lbpc_pkg::CMD_NONE;
    endcase
  end

  assign cmd = {kind, on_t, off_t, cnt, gap_t};

endmodule

>>> rtl/core/lbpc_back.sv
// back end: mode, timer and blink sequencing, one command per clock while a command waits and the result queue has room
module lbpc_back #(
  parameter int TIME_BITS  = lbpc_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = lbpc_pkg::COUNT_BITS_DEFAULT,
  parameter int CMD_BITS   = 3 + 3 * TIME_BITS + COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CMD_BITS-1:0] cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output lbpc_pkg::result_t   res
);

  lbpc_pkg::cmd_kind_t   c_kind;
  logic [TIME_BITS-1:0]  c_on;
  logic [TIME_BITS-1:0]  c_off;
  logic [COUNT_BITS-1:0] c_cnt;
  logic [TIME_BITS-1:0]  c_gap;

  lbpc_pkg::mode_t       mode_now, mode_now_next;
  lbpc_pkg::mode_t       saved_mode, saved_mode_next;
  logic                  lamp, lamp_next;
  logic [COUNT_BITS-1:0] blinks_left, blinks_left_next;
  logic [TIME_BITS-1:0]  cur_on_time, cur_on_time_next;
  logic [TIME_BITS-1:0]  cur_off_time, cur_off_time_next;
  logic [COUNT_BITS-1:0] cur_blink_total, cur_blink_total_next;
  logic [TIME_BITS-1:0]  cur_repeat_gap, cur_repeat_gap_next;
  logic [TIME_BITS-1:0]  timer_left, timer_left_next;
  logic                  timer_armed, timer_armed_next;
  logic [TIME_BITS-1:0]  saved_on_time, saved_on_time_next;
  logic [TIME_BITS-1:0]  saved_off_time, saved_off_time_next;
  logic [COUNT_BITS-1:0] saved_blink_total, saved_blink_total_next;
  logic [TIME_BITS-1:0]  saved_repeat_gap, saved_repeat_gap_next;
  logic [COUNT_BITS-1:0] blinks_dec;
  logic                  fire;
  logic                  rej;

  assign {c_kind, c_on, c_off, c_cnt, c_gap} = cmd;

  assign fire       = !cmd_empty && !res_full;
  assign cmd_pop    = fire;
  assign res_push   = fire;
  assign blinks_dec = (blinks_left != '0) ? blinks_left - COUNT_BITS'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_now          <= lbpc_pkg::MODE_OFF;
      saved_mode        <= lbpc_pkg::MODE_OFF;
      lamp              <= 1'b0;
      blinks_left       <= '0;
      cur_on_time       <= '0;
      cur_off_time      <= '0;
      cur_blink_total   <= '0;
      cur_repeat_gap    <= '0;
      timer_left        <= '0;
      timer_armed       <= 1'b0;
      saved_on_time     <= '0;
      saved_off_time    <= '0;
      saved_blink_total <= '0;
      saved_repeat_gap  <= '0;
    end else if (fire) begin
      mode_now          <= mode_now_next;
      saved_mode        <= saved_mode_next;
      lamp              <= lamp_next;
      blinks_left       <= blinks_left_next;
      cur_on_time       <= cur_on_time_next;
      cur_off_time      <= cur_off_time_next;
      cur_blink_total   <= cur_blink_total_next;
      cur_repeat_gap    <= cur_repeat_gap_next;
      timer_left        <= timer_left_next;
      timer_armed       <= timer_armed_next;
      saved_on_time     <= saved_on_time_next;
      saved_off_time    <= saved_off_time_next;
      saved_blink_total <= saved_blink_total_next;
      saved_repeat_gap  <= saved_repeat_gap_next;
    end
  end

  always_comb begin
    mode_now_next          = mode_now;
    saved_mode_next        = saved_mode;
    lamp_next              = lamp;
    blinks_left_next       = blinks_left;
    cur_on_time_next       = cur_on_time;
    cur_off_time_next      = cur_off_time;
    cur_blink_total_next   = cur_blink_total;
    cur_repeat_gap_next    = cur_repeat_gap;
    timer_left_next        = timer_left;
    timer_armed_next       = timer_armed;
    saved_on_time_next     = saved_on_time;
    saved_off_time_next    = saved_off_time;
    saved_blink_total_next = saved_blink_total;
    saved_repeat_gap_next  = saved_repeat_gap;
    rej                    = 1'b0;

    unique case (c_kind) inside
      lbpc_pkg::CMD_TICK: begin
        if (timer_armed) begin
          if (timer_left <= TIME_BITS'(1)) begin
            timer_left_next  = '0;
            timer_armed_next = 1'b0;
            if (!lamp) begin
              lamp_next        = 1'b1;
              timer_left_next  = cur_on_time;
              timer_armed_next = 1'b1;
            end else begin
              lamp_next        = 1'b0;
              blinks_left_next = blinks_dec;
              if (blinks_dec != '0) begin
                timer_left_next  = cur_off_time;
                timer_armed_next = 1'b1;
              end else if (mode_now == lbpc_pkg::MODE_ONCE) begin
                // burst done: restore saved mode and settings
                cur_on_time_next     = saved_on_time;
                cur_off_time_next    = saved_off_time;
                cur_blink_total_next = saved_blink_total;
                cur_repeat_gap_next  = saved_repeat_gap;
                mode_now_next        = saved_mode;
                if (saved_mode == lbpc_pkg::MODE_OFF || saved_mode == lbpc_pkg::MODE_ON) begin
                  lamp_next        = (saved_mode == lbpc_pkg::MODE_ON);
                  timer_left_next  = '0;
                  timer_armed_next = 1'b0;
                end else begin
                  lamp_next        = 1'b1;
                  blinks_left_next = saved_blink_total;
                  timer_left_next  = saved_on_time;
                  timer_armed_next = 1'b1;
                end
              end else if (mode_now == lbpc_pkg::MODE_CONT) begin
                blinks_left_next = cur_blink_total;
                timer_left_next  = cur_repeat_gap;
                timer_armed_next = 1'b1;
              end
            end
          end else begin
            timer_left_next = timer_left - TIME_BITS'(1);
          end
        end
      end
      lbpc_pkg::CMD_ON, lbpc_pkg::CMD_OFF: begin
        mode_now_next    = (c_kind == lbpc_pkg::CMD_ON) ? lbpc_pkg::MODE_ON : lbpc_pkg::MODE_OFF;
        lamp_next        = (c_kind == lbpc_pkg::CMD_ON);
        timer_left_next  = '0;
        timer_armed_next = 1'b0;
      end
      lbpc_pkg::CMD_ONCE, lbpc_pkg::CMD_CONT: begin
        if (c_kind == lbpc_pkg::CMD_ONCE) begin
          saved_mode_next        = mode_now;
          saved_on_time_next     = cur_on_time;
          saved_off_time_next    = cur_off_time;
          saved_blink_total_next = cur_blink_total;
          saved_repeat_gap_next  = cur_repeat_gap;
          mode_now_next          = lbpc_pkg::MODE_ONCE;
        end else begin
          cur_repeat_gap_next = c_gap;
          mode_now_next       = lbpc_pkg::MODE_CONT;
        end
        cur_on_time_next     = c_on;
        cur_off_time_next    = c_off;
        cur_blink_total_next = c_cnt;
        lamp_next            = 1'b1;
        blinks_left_next     = c_cnt;
        timer_left_next      = c_on;
        timer_armed_next     = 1'b1;
      end
      lbpc_pkg::CMD_REJECT: begin
        rej = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.led_level = lamp_next;
  assign res.rejected  = rej;

endmodule

>>> rtl/core/led_blink_pattern_controller.sv
// top level of the led blink pattern controller
// Drives one status LED from a stream of words, each a 1 ms tick or an on, off,
// blink-once or blink-continuous command, and returns one result word per input
// word carrying the LED level and a reject flag. One word is taken every clock
// unless the command queue is full. The front end decodes and checks each word
// into a two-entry command queue; the back end updates mode, timer and blink
// state per command and writes its result into a two-entry result queue, so
// either side may stall without holding up the other.
module led_blink_pattern_controller #(
  parameter int TIME_BITS  = lbpc_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = lbpc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [15:0] on_time,
  input  logic [15:0] off_time,
  input  logic [15:0] blink_total,
  input  logic [15:0] repeat_gap,
  output logic        empty,
  input  logic        pop,
  output logic        led_level,
  output logic        rejected
);

  localparam int CMD_BITS = 3 + 3 * TIME_BITS + COUNT_BITS;
  localparam int RES_BITS = $bits(lbpc_pkg::result_t);

  logic [CMD_BITS-1:0] cmd_in;
  logic [CMD_BITS-1:0] cmd_head;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_full;
  logic                res_push;
  lbpc_pkg::result_t   res_in;
  lbpc_pkg::result_t   res_head;

  lbpc_front #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CMD_BITS   (CMD_BITS)
  ) u_front (
    .operation   (operation),
    .on_time     (on_time),
    .off_time    (off_time),
    .blink_total (blink_total),
    .repeat_gap  (repeat_gap),
    .cmd         (cmd_in)
  );

  lbpc_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (lbpc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  lbpc_back #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .CMD_BITS   (CMD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  lbpc_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (lbpc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign led_level = res_head.led_level;
  assign rejected  = res_head.rejected;

endmodule

>>> tb/sv/testbench.sv
// testbench for the led blink pattern controller: directed and random command and tick stream with checking
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_WORDS = 1000;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] count;
    logic [15:0] gap;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  operation = lbpc_pkg::OP_TICK;
  logic [15:0] on_time = '0;
  logic [15:0] off_time = '0;
  logic [15:0] blink_total = '0;
  logic [15:0] repeat_gap = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        led_level;
  logic        rejected;

  led_blink_pattern_controller u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .on_time(on_time),
    .off_time(off_time),
    .blink_total(blink_total),
    .repeat_gap(repeat_gap),
    .empty(empty),
    .pop(pop),
    .led_level(led_level),
    .rejected(rejected)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // led state as the block should hold it
  lbpc_pkg::mode_t led_mode = lbpc_pkg::MODE_OFF;
  lbpc_pkg::mode_t keep_mode = lbpc_pkg::MODE_OFF;
  logic        lamp_lit = 1'b0;
  logic        timer_run = 1'b0;
  logic [15:0] timer_ms = '0;
  logic [15:0] blinks_to_go = '0;
  logic [15:0] on_ms = '0;
  logic [15:0] off_ms = '0;
  logic [15:0] burst_len = '0;
  logic [15:0] gap_ms = '0;
  logic [15:0] keep_on = '0;
  logic [15:0] keep_off = '0;
  logic [15:0] keep_len = '0;
  logic [15:0] keep_gap = '0;

  word_t             pending_words[$];
  lbpc_pkg::result_t led_results_due[$];
  int      bad_count = 0;
  int      cycles = 0;
  bit      word_taken = 1'b0;
  int      burst_left = 0;
  int      idle_left = 0;
  int      pop_style = 0;
  int      pop_phase_left = 0;

  task automatic enter_led_mode(input lbpc_pkg::mode_t m);
    led_mode = m;
    if (m == lbpc_pkg::MODE_OFF || m == lbpc_pkg::MODE_ON) begin
      lamp_lit = (m == lbpc_pkg::MODE_ON);
      timer_run = 1'b0;
      timer_ms = '0;
    end else begin
      lamp_lit = 1'b1;
      blinks_to_go = burst_len;
      timer_ms = on_ms;
      timer_run = 1'b1;
    end
  endtask

  task automatic timer_expired();
    if (!lamp_lit) begin
      lamp_lit = 1'b1;
      timer_ms = on_ms;
      timer_run = 1'b1;
    end else begin
      lamp_lit = 1'b0;
      if (blinks_to_go != 0) blinks_to_go = blinks_to_go - 1'b1;
      if (blinks_to_go != 0) begin
        timer_ms = off_ms;
        timer_run = 1'b1;
      end else if (led_mode == lbpc_pkg::MODE_ONCE) begin
        on_ms = keep_on;
        off_ms = keep_off;
        burst_len = keep_len;
        gap_ms = keep_gap;
        enter_led_mode(keep_mode);
      end else if (led_mode == lbpc_pkg::MODE_CONT) begin
        blinks_to_go = burst_len;
        timer_ms = gap_ms;
        timer_run = 1'b1;
      end
    end
  endtask

  task automatic advance_led(input word_t w, output lbpc_pkg::result_t r);
    logic refused;
    refused = 1'b0;
    case (w.op) inside
      lbpc_pkg::OP_TICK: begin
        if (timer_run) begin
          if (timer_ms <= 16'd1) begin
            timer_ms = '0;
            timer_run = 1'b0;
            timer_expired();
          end else begin
            timer_ms = timer_ms - 1'b1;
          end
        end
      end
      lbpc_pkg::OP_ON: enter_led_mode(lbpc_pkg::MODE_ON);
      lbpc_pkg::OP_OFF: enter_led_mode(lbpc_pkg::MODE_OFF);
      lbpc_pkg::OP_BLINK_ONCE, lbpc_pkg::OP_BLINK_CONT: begin
        if (w.on_ms == 0 || (w.off_ms == 0 && w.count != 0)) begin
          refused = 1'b1;
        end else begin
          if (w.op == lbpc_pkg::OP_BLINK_ONCE) begin
            keep_mode = led_mode;
            keep_on = on_ms;
            keep_off = off_ms;
            keep_len = burst_len;
            keep_gap = gap_ms;
          end else begin
            gap_ms = w.gap;
          end
          on_ms = w.on_ms;
          off_ms = w.off_ms;
          burst_len = w.count;
          enter_led_mode(w.op == lbpc_pkg::OP_BLINK_ONCE ? lbpc_pkg::MODE_ONCE
                                                         : lbpc_pkg::MODE_CONT);
        end
      end
      default: ;
    endcase
    r.led_level = lamp_lit;
    r.rejected = refused;
  endtask

  function automatic word_t mk(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d);
    word_t w;
    w.op = op;
    w.on_ms = a;
    w.off_ms = b;
    w.count = c;
    w.gap = d;
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w = mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0);
    if ($urandom_range(0, 3) == 0) begin
      w = mk(lbpc_pkg::OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    if (pick < 58) begin
      w.op = lbpc_pkg::OP_TICK;
    end else if (pick < 66) begin
      w.op = lbpc_pkg::OP_ON;
    end else if (pick < 72) begin
      w.op = lbpc_pkg::OP_OFF;
    end else if (pick < 76) begin
      w.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
    end else if (pick < 94) begin
      // short well-formed bursts, a few broken ones
      w = mk($urandom_range(0, 1) ? lbpc_pkg::OP_BLINK_ONCE : lbpc_pkg::OP_BLINK_CONT,
             16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
             16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)));
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1)) begin
          w.on_ms = '0;
        end else begin
          w.off_ms = '0;
          w.count = 16'($urandom_range(1, 4));
        end
      end
    end else begin
      w = mk($urandom_range(0, 1) ? lbpc_pkg::OP_BLINK_ONCE : lbpc_pkg::OP_BLINK_CONT,
             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    return w;
  endfunction

  // sender: bursts of words with idle gaps
  always @(negedge clk) begin : drive
    logic  nxt_push;
    word_t nxt;
    nxt_push = push;
    nxt = mk(operation, on_time, off_time, blink_total, repeat_gap);
    if (rst) begin
      nxt_push = 1'b0;
    end else begin
      if (push && word_taken) nxt_push = 1'b0;
      word_taken = 1'b0;
      if (!nxt_push) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          nxt_push = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
    push <= nxt_push;
    operation <= nxt.op;
    on_time <= nxt.on_ms;
    off_time <= nxt.off_ms;
    blink_total <= nxt.count;
    repeat_gap <= nxt.gap;
  end

  // receiver: stall pattern that changes style now and then
  always @(negedge clk) begin : take
    logic nxt_pop;
    if (pop_phase_left == 0) begin
      pop_style = $urandom_range(0, 3);
      pop_phase_left = $urandom_range(1, 40);
    end
    pop_phase_left--;
    case (pop_style)
      0: nxt_pop = 1'b1;
      1: nxt_pop = 1'($urandom_range(0, 1));
      2: nxt_pop = ($urandom_range(0, 3) == 0);
      default: nxt_pop = 1'b0;
    endcase
    pop <= rst ? 1'b0 : nxt_pop;
  end

  always @(posedge clk) begin : watch
    lbpc_pkg::result_t want;
    lbpc_pkg::result_t got;
    if (!rst) begin
      if (push && !full) begin
        advance_led(mk(operation, on_time, off_time, blink_total, repeat_gap), want);
        led_results_due.push_back(want);
        word_taken = 1'b1;
      end
      if (pop && !empty) begin
        got.led_level = led_level;
        got.rejected = rejected;
        if (led_results_due.size() == 0) begin
          $error("result word with nothing expected: led_level %0b rejected %0b",
                 got.led_level, got.rejected);
          bad_count++;
        end else begin
          want = led_results_due.pop_front();
          if (got.led_level !== want.led_level) begin
            $error("led_level mismatch: expected %0b, actual %0b", want.led_level, got.led_level);
            bad_count++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected mismatch: expected %0b, actual %0b", want.rejected, got.rejected);
            bad_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_ON, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_OFF, '0, '0, '0, '0));
    // refused: zero on time, then zero off time with a count
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_ONCE, 16'd0, 16'd3, 16'd2, 16'd0));
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_CONT, 16'd2, 16'd0, 16'd3, 16'd1));
    // zero count ends after the first lit phase
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_ONCE, 16'd2, 16'd0, 16'd0, 16'd0));
    pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    // nested one-shot over steady on
    pending_words.push_back(mk(lbpc_pkg::OP_ON, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_ONCE, 16'd1, 16'd1, 16'd2, 16'd0));
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_ONCE, 16'd1, 16'd1, 16'd1, 16'd0));
    repeat (6) pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_CONT, 16'd1, 16'd2, 16'd1, 16'd0));
    repeat (4) pending_words.push_back(mk(lbpc_pkg::OP_TICK, '1, '1, '1, '1));
    pending_words.push_back(mk(OP_SPARE5, '1, '1, '1, '1));
    pending_words.push_back(mk(OP_SPARE6, '0, '0, '0, '0));
    pending_words.push_back(mk(OP_SPARE7, '1, '1, '1, '1));
    pending_words.push_back(mk(lbpc_pkg::OP_BLINK_CONT, '1, '1, '1, '1));
    pending_words.push_back(mk(lbpc_pkg::OP_ON, '1, '1, '1, '1));
    pending_words.push_back(mk(lbpc_pkg::OP_TICK, '0, '0, '0, '0));
    pending_words.push_back(mk(lbpc_pkg::OP_OFF, '0, '0, '0, '0));
    for (int i = 0; i < RANDOM_WORDS; i++) pending_words.push_back(rand_word());

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || push) @(posedge clk);
    while (led_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> led_blink_pattern_controller.f
rtl/core/lbpc_pkg.sv
rtl/core/lbpc_fifo.sv
rtl/core/lbpc_front.sv
rtl/core/lbpc_back.sv
rtl/core/led_blink_pattern_controller.sv
tb/sv/testbench.sv
